@@ rtl/eplc_pkg.sv @@
// ----------------------------------------------------------------------------
// eplc_pkg
// shared types, constants and controller/datapath command types for the cache
// ----------------------------------------------------------------------------
package eplc_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned CfgWidth        = 5;
  localparam logic [CfgWidth-1:0] CfgReset = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [31:0] key_tag;
    logic [31:0] new_value;
    logic [31:0] new_priority;
    logic [31:0] new_expiry;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_HIT,
    ST_VSCAN,
    ST_DROP,
    ST_ALLOC,
    ST_INSERT,
    ST_TOUCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic do_hit;
    logic do_drop;
    logic do_insert;
    logic do_touch;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic is_set;
    logic full;
    logic victim_ok;
    logic free_ok;
  } sts_t;

endpackage

@@ rtl/expiry_priority_lru_cache_unit.sv @@
// ----------------------------------------------------------------------------
// expiry_priority_lru_cache_unit
// key/value cache with expiry, priority and lru eviction
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_ready | eplc_pkg::req_t
// out     | out | out_valid/ready   | eplc_pkg::rsp_t
// cfg     | in  | cfg_valid/ready   | capacity_in_use, 5 bits
//
// every request runs a lookup scan; a set miss adds a free-slot scan, preceded by a
// victim scan and drop when full (sequential slot scans of the entry store)
// reset clears all valid bits and occupancy, limit resets to 16
// a result waits in the output register; a stalled output holds the sequencer
// ----------------------------------------------------------------------------
module expiry_priority_lru_cache_unit #(
  parameter int unsigned Capacity = eplc_pkg::CapacityDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  eplc_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output eplc_pkg::rsp_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [eplc_pkg::CfgWidth-1:0] cfg_data_i
);
  import eplc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic out_valid_q;
  logic [CfgWidth-1:0] limit_q;
  logic in_fire;

  // accept a new transaction only while the sequencer is idle
  assign in_ready_o  = idle;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (cmd.load_rsp) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  eplc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_busy_i (out_valid_q && !out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  eplc_dp #(.Capacity(Capacity)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .limit_cfg_i (limit_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_data_o)
  );

endmodule

@@ rtl/eplc_ctrl.sv @@
// ----------------------------------------------------------------------------
// eplc_ctrl
// sequencer for lookup, victim scan, eviction and insert
// ----------------------------------------------------------------------------
module eplc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_busy_i,
  input  eplc_pkg::sts_t  sts_i,
  output eplc_pkg::cmd_t  cmd_o,
  output logic            idle_o
);
  import eplc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire_i) state_d = ST_FIND;
      ST_FIND: begin
        if (sts_i.found) state_d = ST_HIT;
        else if (sts_i.scan_last) begin
          if (!sts_i.is_set) state_d = ST_DONE;
          else if (sts_i.full) state_d = ST_VSCAN;
          else state_d = ST_ALLOC;
        end
      end
      ST_HIT:    state_d = ST_TOUCH;
      ST_TOUCH:  state_d = ST_DONE;
      ST_VSCAN:  if (sts_i.scan_last) state_d = ST_DROP;
      ST_DROP:   state_d = ST_ALLOC;
      ST_ALLOC:  if (sts_i.scan_last) state_d = ST_INSERT;
      ST_INSERT: state_d = ST_DONE;
      ST_DONE:   if (!out_busy_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_req   = in_fire_i;
        cmd_o.scan_start = in_fire_i;
      end
      ST_FIND: begin
        cmd_o.scan_step  = !sts_i.found;
        cmd_o.scan_start = sts_i.scan_last && !sts_i.found;
      end
      ST_HIT:    cmd_o.do_hit = 1'b1;
      ST_TOUCH:  cmd_o.do_touch = 1'b1;
      ST_VSCAN:  cmd_o.scan_step = 1'b1;
      ST_DROP: begin
        cmd_o.do_drop    = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      ST_ALLOC:  cmd_o.scan_step = 1'b1;
      ST_INSERT: cmd_o.do_insert = 1'b1;
      ST_DONE:   cmd_o.load_rsp = !out_busy_i;
      default:   cmd_o = '0;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

@@ rtl/eplc_dp.sv @@
// ----------------------------------------------------------------------------
// eplc_dp
// entry storage, one-slot-per-cycle scan unit and recency update
// ----------------------------------------------------------------------------
module eplc_dp #(
  parameter int unsigned Capacity = eplc_pkg::CapacityDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  eplc_pkg::req_t                   req_i,
  input  logic [eplc_pkg::CfgWidth-1:0]    limit_cfg_i,
  input  eplc_pkg::cmd_t                   cmd_i,
  output eplc_pkg::sts_t                   sts_o,
  output eplc_pkg::rsp_t                   rsp_o
);
  import eplc_pkg::*;

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned LimW = (CntW > CfgWidth) ? CntW : CfgWidth;

  logic             valid_q [Capacity];
  logic [31:0]      key_q   [Capacity];
  logic [31:0]      val_q   [Capacity];
  logic [31:0]      pri_q   [Capacity];
  logic [31:0]      exp_q   [Capacity];
  logic [IdxW-1:0]  rec_q   [Capacity];
  logic [CntW-1:0]  count_q;

  req_t             req_q;
  rsp_t             rsp_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  slot_q;
  logic             slot_ok_q;
  logic [IdxW-1:0]  old_rec_q;
  logic             hit_q, ev_q;
  logic [31:0]      evk_q, rdv_q;

  // effective limit: zero acts as one, clamp to capacity
  logic [LimW-1:0] lim;
  always_comb begin
    lim = LimW'(limit_cfg_i);
    if (lim == '0) lim = LimW'(1);
    if (lim > LimW'(Capacity)) lim = LimW'(Capacity);
  end

  logic cur_v;
  logic better;
  assign cur_v = valid_q[idx_q];

  // expiry, then priority, then least recent
  always_comb begin
    better = 1'b0;
    if (!slot_ok_q) better = 1'b1;
    else if ($signed(exp_q[idx_q]) < $signed(exp_q[slot_q])) better = 1'b1;
    else if (exp_q[idx_q] == exp_q[slot_q]) begin
      if ($signed(pri_q[idx_q]) < $signed(pri_q[slot_q])) better = 1'b1;
      else if (pri_q[idx_q] == pri_q[slot_q] && rec_q[idx_q] < rec_q[slot_q])
        better = 1'b1;
    end
  end

  assign sts_o.scan_last = (idx_q == IdxW'(Capacity - 1));
  assign sts_o.found     = cur_v && (key_q[idx_q] == req_q.key_tag);
  assign sts_o.is_set    = req_q.op;
  assign sts_o.full      = (LimW'(count_q) >= lim);
  assign sts_o.victim_ok = slot_ok_q;
  assign sts_o.free_ok   = slot_ok_q;
  assign rsp_o           = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Capacity; i++) valid_q[i] <= 1'b0;
      count_q <= '0;
    end else begin
      if (cmd_i.do_drop && slot_ok_q) begin
        valid_q[slot_q] <= 1'b0;
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.do_insert && slot_ok_q && (LimW'(count_q) < lim)) begin
        valid_q[slot_q] <= 1'b1;
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
      hit_q <= 1'b0;
      ev_q  <= 1'b0;
      evk_q <= '0;
      rdv_q <= (req_i.op == OP_GET) ? 32'hFFFF_FFFF : 32'h0;
    end
    if (cmd_i.scan_start) begin
      idx_q     <= '0;
      slot_ok_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + IdxW'(1);
      // victim scan while full, first free slot otherwise
      if (req_q.op && hit_q == 1'b0) begin
        if (sts_o.full) begin
          if (cur_v && better) begin
            slot_q <= idx_q;
            slot_ok_q <= 1'b1;
          end
        end else if (!cur_v && !slot_ok_q) begin
          slot_q <= idx_q;
          slot_ok_q <= 1'b1;
        end
      end
    end
    // the lookup scan stopped on the matching slot
    if (cmd_i.do_hit) begin
      hit_q     <= 1'b1;
      slot_q    <= idx_q;
      old_rec_q <= rec_q[idx_q];
      if (req_q.op == OP_GET) rdv_q <= val_q[idx_q];
      else begin
        val_q[idx_q] <= req_q.new_value;
        pri_q[idx_q] <= req_q.new_priority;
        exp_q[idx_q] <= req_q.new_expiry;
      end
    end
    if (cmd_i.do_touch) begin
      for (int i = 0; i < Capacity; i++)
        if (valid_q[i] && rec_q[i] > old_rec_q) rec_q[i] <= rec_q[i] - IdxW'(1);
      rec_q[slot_q] <= IdxW'(count_q - CntW'(1));
    end
    if (cmd_i.do_drop && slot_ok_q) begin
      ev_q  <= 1'b1;
      evk_q <= key_q[slot_q];
      for (int i = 0; i < Capacity; i++)
        if (valid_q[i] && rec_q[i] > rec_q[slot_q]) rec_q[i] <= rec_q[i] - IdxW'(1);
    end
    if (cmd_i.do_insert && slot_ok_q && (LimW'(count_q) < lim)) begin
      key_q[slot_q] <= req_q.key_tag;
      val_q[slot_q] <= req_q.new_value;
      pri_q[slot_q] <= req_q.new_priority;
      exp_q[slot_q] <= req_q.new_expiry;
      rec_q[slot_q] <= IdxW'(count_q);
    end
    if (cmd_i.load_rsp) begin
      rsp_q.hit         <= hit_q;
      rsp_q.read_value  <= rdv_q;
      rsp_q.evicted     <= ev_q;
      rsp_q.evicted_key <= evk_q;
    end
  end

endmodule
